[hdl/rle_pkg.sv]
package rle_pkg;

    // Fixed by the byte format of the token stream
    localparam logic [7:0] REPEAT_MAX   = 8'd129;
    localparam logic [7:0] REP_HDR_BASE = 8'd126;
    localparam logic [7:0] PAIR_LEN     = 8'd2;
    localparam int         WORD_BYTES   = 8;
    localparam int         QUEUE_DEPTH  = 4;

    // One descriptor per input transaction that completes at least one token
    typedef struct packed {
        logic       rep_en;
        logic       rep_first;
        logic [7:0] rep_hdr;
        logic [7:0] rep_val;
        logic [7:0] lit_n;
        logic       last;
    } t_desc;

    // Literal store write port
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_st_wr;

endpackage

[hdl/rle_front.sv]
module rle_front
    import rle_pkg::*;
#(
    parameter int LITERAL_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_full,
    input  logic       i_lit_done,
    output logic       o_stall,
    output logic       o_push,
    output t_desc      o_desc,
    output t_st_wr     o_st_wr
);

    localparam logic [7:0] FILL_MAX = 8'(LITERAL_DEPTH);

    logic       r_rep_mode, n_rep_mode;
    logic [7:0] r_rep_val, n_rep_val;
    logic [7:0] r_rep_len, n_rep_len;
    logic [7:0] r_fill, n_fill;
    logic [7:0] r_prev, n_prev;
    logic       r_busy;

    logic       take;
    logic       rep_en;
    logic       rep_first;
    logic [7:0] rep_len_out;
    logic [7:0] rep_val_out;
    logic [7:0] lit_n;
    logic [7:0] rep_len_inc;
    logic [7:0] fill_inc;

    // Hold input while the back still reads a queued literal from the store, or while the queue is full
    assign o_stall     = r_busy || i_q_full;
    assign take        = i_valid && !o_stall;
    assign rep_len_inc = r_rep_len + 8'd1;
    assign fill_inc    = r_fill + 8'd1;
    assign o_push      = take && (rep_en || lit_n != '0);

    always_comb begin
        n_rep_mode   = r_rep_mode;
        n_rep_val    = r_rep_val;
        n_rep_len    = r_rep_len;
        n_fill       = r_fill;
        n_prev       = r_prev;
        rep_en       = 1'b0;
        rep_first    = 1'b0;
        rep_len_out  = r_rep_len;
        rep_val_out  = r_rep_val;
        lit_n        = '0;
        o_st_wr.en   = 1'b0;
        o_st_wr.addr = r_fill;
        o_st_wr.data = i_byte;
        priority if (r_rep_mode) begin
            if (i_byte == r_rep_val) begin
                n_rep_len = rep_len_inc;
                // close the repeat run at its longest length
                if (rep_len_inc >= REPEAT_MAX) begin
                    rep_en      = 1'b1;
                    rep_len_out = rep_len_inc;
                    n_rep_mode  = 1'b0;
                    n_rep_len   = '0;
                end
            end else begin
                rep_en       = 1'b1;
                rep_first    = 1'b1;
                n_rep_mode   = 1'b0;
                n_rep_len    = '0;
                o_st_wr.en   = take;
                o_st_wr.addr = '0;
                n_fill       = 8'd1;
                n_prev       = i_byte;
            end
        end else if (r_fill == '0) begin
            o_st_wr.en   = take;
            o_st_wr.addr = '0;
            n_fill       = 8'd1;
            n_prev       = i_byte;
        end else if (i_byte == r_prev) begin
            // a pair closes the literal run before it
            lit_n      = r_fill - 8'd1;
            n_fill     = '0;
            n_rep_mode = 1'b1;
            n_rep_val  = i_byte;
            n_rep_len  = PAIR_LEN;
        end else begin
            o_st_wr.en = take;
            n_fill     = fill_inc;
            n_prev     = i_byte;
            if (fill_inc >= FILL_MAX) begin
                lit_n  = fill_inc;
                n_fill = '0;
            end
        end
        // flush whatever run is pending at end of stream
        if (i_last) begin
            if (n_rep_mode) begin
                rep_en      = 1'b1;
                rep_len_out = n_rep_len;
                rep_val_out = n_rep_val;
            end else if (n_fill != '0) begin
                lit_n = n_fill;
            end
            n_rep_mode = 1'b0;
            n_rep_len  = '0;
            n_fill     = '0;
        end
        o_desc.rep_en    = rep_en;
        o_desc.rep_first = rep_first;
        o_desc.rep_hdr   = REP_HDR_BASE + rep_len_out;
        o_desc.rep_val   = rep_val_out;
        o_desc.lit_n     = lit_n;
        o_desc.last      = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_mode <= 1'b0;
            r_rep_val  <= '0;
            r_rep_len  <= '0;
            r_fill     <= '0;
            r_prev     <= '0;
            r_busy     <= 1'b0;
        end else begin
            if (take) begin
                r_rep_mode <= n_rep_mode;
                r_rep_val  <= n_rep_val;
                r_rep_len  <= n_rep_len;
                r_fill     <= n_fill;
                r_prev     <= n_prev;
            end
            if (i_lit_done) begin
                r_busy <= 1'b0;
            end else if (o_push && lit_n != '0) begin
                r_busy <= 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("push into a full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_stall)
        else $error("input taken while literal store is busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < FILL_MAX))
        else $error("literal fill past store depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_mode |-> (r_fill == '0 && r_rep_len >= PAIR_LEN && r_rep_len < REPEAT_MAX))
        else $error("repeat run state out of range");

endmodule

[hdl/rle_fifo.sv]
module rle_fifo
    import rle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_desc o_desc
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_desc           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(QUEUE_DEPTH)))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a push");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty |-> (r_wptr == r_rptr)))
        else $error("empty queue with pointer mismatch");

endmodule

[hdl/rle_back.sv]
module rle_back
    import rle_pkg::*;
#(
    parameter int LITERAL_DEPTH = 128,
    parameter int OUT_BYTES     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_st_wr      i_st_wr,
    input  logic        i_q_empty,
    input  t_desc       i_q_desc,
    output logic        o_pop,
    output logic        o_lit_done,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_word,
    output logic [3:0]  o_out_count,
    output logic        o_run_last,
    output logic        o_stream_done
);

    localparam int AW = $clog2(LITERAL_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REP_HDR,
        S_REP_VAL,
        S_LIT_HDR,
        S_LIT_DATA
    } t_state;

    t_state       r_state, n_state;
    t_desc        r_desc;
    logic [7:0]   r_idx;
    logic [7:0]   r_mem [LITERAL_DEPTH];
    logic [7:0]   r_rd_data;
    logic [63:0]  r_word;
    logic [3:0]   r_cnt;
    logic         r_out_valid;
    logic [63:0]  r_out_word;
    logic [3:0]   r_out_cnt;
    logic         r_out_run_last;
    logic         r_out_done;

    logic         adv;
    logic         rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]   idx_inc;
    logic         last_lit;
    logic [7:0]   byte_val;
    logic         byte_last;
    logic [63:0]  word_n;
    logic [3:0]   cnt_inc;
    logic         flush;
    t_state       first_state;

    assign o_valid       = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_out_count   = r_out_cnt;
    assign o_run_last    = r_out_run_last;
    assign o_stream_done = r_out_done;

    assign adv      = (r_state != S_IDLE) && (!r_out_valid || !i_stall);
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign idx_inc  = r_idx + 8'd1;
    assign last_lit = (r_idx == r_desc.lit_n - 8'd1);
    assign rd_en    = adv && ((r_state == S_LIT_HDR) || (r_state == S_LIT_DATA));
    assign rd_addr  = (r_state == S_LIT_HDR) ? '0 : idx_inc[AW-1:0];
    assign o_lit_done = adv && (r_state == S_LIT_DATA) && last_lit;

    assign first_state = (i_q_desc.rep_en && (i_q_desc.rep_first || i_q_desc.lit_n == '0))
                         ? S_REP_HDR : S_LIT_HDR;

    // Byte source and next phase for the current token position
    always_comb begin
        byte_val  = '0;
        byte_last = 1'b0;
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                n_state = o_pop ? first_state : S_IDLE;
            end
            S_REP_HDR: begin
                byte_val = r_desc.rep_hdr;
                n_state  = S_REP_VAL;
            end
            S_REP_VAL: begin
                byte_val = r_desc.rep_val;
                if (r_desc.rep_first && r_desc.lit_n != '0) begin
                    n_state = S_LIT_HDR;
                end else begin
                    byte_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_LIT_HDR: begin
                byte_val = r_desc.lit_n - 8'd1;
                n_state  = S_LIT_DATA;
            end
            S_LIT_DATA: begin
                byte_val = r_rd_data;
                if (last_lit) begin
                    if (r_desc.rep_en && !r_desc.rep_first) begin
                        n_state = S_REP_HDR;
                    end else begin
                        byte_last = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Pack the byte into the next free lane
    always_comb begin
        word_n = r_word;
        for (int j = 0; j < WORD_BYTES; j++) begin
            if (4'(j) == r_cnt) begin
                word_n[8*j +: 8] = byte_val;
            end
        end
        cnt_inc = r_cnt + 4'd1;
        flush   = byte_last || (cnt_inc == 4'(OUT_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (i_st_wr.en) begin
            r_mem[i_st_wr.addr[AW-1:0]] <= i_st_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_word      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            if (adv && flush) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_desc  <= i_q_desc;
                r_state <= n_state;
            end else if (adv) begin
                r_state <= n_state;
                if (r_state == S_LIT_HDR) begin
                    r_idx <= '0;
                end else if (r_state == S_LIT_DATA) begin
                    r_idx <= idx_inc;
                end
                if (flush) begin
                    r_out_word     <= word_n;
                    r_out_cnt      <= cnt_inc;
                    r_out_run_last <= byte_last;
                    r_out_done     <= byte_last && r_desc.last;
                    r_word         <= '0;
                    r_cnt          <= '0;
                end else begin
                    r_word <= word_n;
                    r_cnt  <= cnt_inc;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt != '0 && r_out_cnt <= 4'(OUT_BYTES)))
        else $error("output byte count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_run_last)
        else $error("end of stream without end of run");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIT_DATA) |-> (r_idx < r_desc.lit_n))
        else $error("literal index past token length");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt < 4'(OUT_BYTES)))
        else $error("packer lane count overflow");

endmodule

[hdl/rle_packbits_style_encoder.sv]
// Byte run-length encoder (type 1 tokens: repeat runs and literal runs).
// Input channel: i_valid / o_stall carry one raw byte and an end-of-stream
// mark per transaction. Output channel: o_valid / i_stall carry packed words
// of up to OUT_BYTES token bytes, first byte in bits 7..0, with a byte count,
// an end-of-item flag and an end-of-stream flag.
// The front classifies each byte and queues a descriptor of the tokens it
// completes; the back expands descriptors one byte per cycle unless stalled.
// Throughput: the front takes one byte per cycle while the queue has room and
// no literal read is pending. The back fetches each descriptor, then emits its
// token bytes, so a dense series of short repeat tokens can fill the queue and
// stall input. A byte that completes a literal token holds off input until the
// back has read the literal store, which has a single read port feeding one
// byte per cycle to the packer while the output is not stalled.
// Reset clears all run state and the queue; the literal store needs no clear.
// When the receiver stalls, the output word holds and the back halts; the
// front keeps taking bytes until the queue fills or a literal read is pending.
module rle_packbits_style_encoder
    import rle_pkg::*;
#(
    parameter int LITERAL_DEPTH = 128,
    parameter int OUT_BYTES     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_word,
    output logic [3:0]  o_out_count,
    output logic        o_run_last,
    output logic        o_stream_done
);

    logic   push, pop, q_full, q_empty, lit_done;
    t_desc  desc_in, desc_out;
    t_st_wr st_wr;

    rle_front #(
        .LITERAL_DEPTH (LITERAL_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .i_q_full   (q_full),
        .i_lit_done (lit_done),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_desc     (desc_in),
        .o_st_wr    (st_wr)
    );

    rle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_desc  (desc_out)
    );

    rle_back #(
        .LITERAL_DEPTH (LITERAL_DEPTH),
        .OUT_BYTES     (OUT_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_st_wr       (st_wr),
        .i_q_empty     (q_empty),
        .i_q_desc      (desc_out),
        .o_pop         (pop),
        .o_lit_done    (lit_done),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_word    (o_out_word),
        .o_out_count   (o_out_count),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

endmodule
